// ===== rtl/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants for the servo surface mixer.
// ----------------------------------------------------------------------------
package ssm_pkg;

    // command field width, two's complement
    localparam int CMD_W = 16;

    // duty, limit and drive width
    localparam int DUTY_W = 12;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register reset values
    localparam logic [DUTY_W-1:0] DUTY_MIN_RST   = 12'd400;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RST   = 12'd1100;
    localparam logic [DUTY_W-1:0] YAW_LIMIT_RST  = 12'd1100;
    localparam logic [DUTY_W-1:0] WEIGHT_MIN_RST = 12'd400;
    localparam logic [DUTY_W-1:0] WEIGHT_MAX_RST = 12'd1100;

    // register index, byte address / 4
    typedef enum logic [2:0] {
        REG_DUTY_MIN   = 3'd0,
        REG_DUTY_MAX   = 3'd1,
        REG_YAW_LIMIT  = 3'd2,
        REG_WEIGHT_MIN = 3'd3,
        REG_WEIGHT_MAX = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [CMD_W-1:0] pitch_cmd;
        logic signed [CMD_W-1:0] roll_cmd;
        logic signed [CMD_W-1:0] yaw_cmd;
        logic signed [CMD_W-1:0] flap_cmd;
    } t_mix_in;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_one;
        logic [DUTY_W-1:0] duty_two;
        logic [DUTY_W-1:0] duty_three;
        logic [DUTY_W-1:0] duty_four;
        logic [DUTY_W-1:0] duty_five;
        logic [DUTY_W-1:0] duty_six;
        logic [DUTY_W-1:0] duty_average;
        logic [DUTY_W-1:0] weight_drive;
    } t_mix_out;

endpackage

// ===== rtl/servo_surface_mixer.sv =====
// ----------------------------------------------------------------------------
// servo_surface_mixer
// Five registered stages lie between an accepted command word and its result word.
// Throughput: one word per cycle; the five stages advance together and all
// hold while a result word waits under stall.
// Reset: synchronous active low; clears stage valid bits and loads the
// register defaults (duty 400..1100, yaw limit 1100, weight 400..1100).
// ----------------------------------------------------------------------------
module servo_surface_mixer
    import ssm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_mix_in           i_in_word,

    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_mix_out          o_out_word,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // signed working width for the mixing sums and the weight difference
    localparam int SW = ((CMD_W > DUTY_W + 1) ? CMD_W : DUTY_W + 1) + 4;

    // floor(s / 6) = (s * RECIP) >> RSH for every s below 2^SUM_W
    localparam int SUM_W = DUTY_W + 3;
    localparam int RSH   = SUM_W + 3;
    localparam int RCP_W = RSH - 2;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(((1 << RSH) + 5) / 6);
    localparam int PROD_W = SUM_W + RCP_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DUTY_W-1:0] r_duty_min;
    logic [DUTY_W-1:0] r_duty_max;
    logic [DUTY_W-1:0] r_yaw_limit;
    logic [DUTY_W-1:0] r_weight_min;
    logic [DUTY_W-1:0] r_weight_max;
    t_reg_idx          reg_idx;
    logic              cfg_wr;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_min   <= DUTY_MIN_RST;
            r_duty_max   <= DUTY_MAX_RST;
            r_yaw_limit  <= YAW_LIMIT_RST;
            r_weight_min <= WEIGHT_MIN_RST;
            r_weight_max <= WEIGHT_MAX_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DUTY_MIN:   r_duty_min   <= pwdata[DUTY_W-1:0];
                REG_DUTY_MAX:   r_duty_max   <= pwdata[DUTY_W-1:0];
                REG_YAW_LIMIT:  r_yaw_limit  <= pwdata[DUTY_W-1:0];
                REG_WEIGHT_MIN: r_weight_min <= pwdata[DUTY_W-1:0];
                REG_WEIGHT_MAX: r_weight_max <= pwdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DUTY_MIN:   prdata = DATA_W'(r_duty_min);
            REG_DUTY_MAX:   prdata = DATA_W'(r_duty_max);
            REG_YAW_LIMIT:  prdata = DATA_W'(r_yaw_limit);
            REG_WEIGHT_MIN: prdata = DATA_W'(r_weight_min);
            REG_WEIGHT_MAX: prdata = DATA_W'(r_weight_max);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control: all stages move together
    // ------------------------------------------------------------------
    logic adv;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    assign adv         = !(r_v5 && i_out_stall);
    assign o_in_stall  = !adv;
    assign o_out_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: one-sided yaw terms
    // ------------------------------------------------------------------
    logic signed [SW-1:0] y_x;
    logic signed [SW-1:0] ny_x;
    logic signed [SW-1:0] lim_x;
    logic [DUTY_W-1:0]    n_yp;
    logic [DUTY_W-1:0]    n_yn;

    logic signed [CMD_W-1:0] r_p1, r_r1, r_f1;
    logic [DUTY_W-1:0]       r_yp1, r_yn1;

    always_comb begin
        y_x   = SW'(i_in_word.yaw_cmd);
        ny_x  = -y_x;
        lim_x = signed'(SW'(r_yaw_limit));
        if (y_x >= lim_x) begin
            n_yp = r_yaw_limit;
        end else if (y_x < 0) begin
            n_yp = '0;
        end else begin
            n_yp = y_x[DUTY_W-1:0];
        end
        if (ny_x >= lim_x) begin
            n_yn = r_yaw_limit;
        end else if (ny_x < 0) begin
            n_yn = '0;
        end else begin
            n_yn = ny_x[DUTY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1  <= i_in_word.pitch_cmd;
            r_r1  <= i_in_word.roll_cmd;
            r_f1  <= i_in_word.flap_cmd;
            r_yp1 <= n_yp;
            r_yn1 <= n_yn;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: six gain sums, each clamped to the duty range
    // ------------------------------------------------------------------
    logic signed [SW-1:0] p_x, r_x, yp_x, yn_x, p3, r3;
    logic signed [SW-1:0] mix [6];
    logic [DUTY_W-1:0]    n_d2 [6];
    logic signed [SW-1:0] dmin_x, dmax_x;

    logic [DUTY_W-1:0]       r_d2 [6];
    logic signed [CMD_W-1:0] r_f2;

    always_comb begin
        p_x    = SW'(r_p1);
        r_x    = SW'(r_r1);
        yp_x   = signed'(SW'(r_yp1));
        yn_x   = signed'(SW'(r_yn1));
        p3     = (p_x <<< 1) + p_x;
        r3     = (r_x <<< 1) + r_x;
        dmin_x = signed'(SW'(r_duty_min));
        dmax_x = signed'(SW'(r_duty_max));

        mix[0] = p_x - yp_x - r3;
        mix[1] = (p_x <<< 1) + (yp_x <<< 1) - (r_x <<< 1);
        mix[2] = p3 - yp_x - r_x;
        mix[3] = p3 - yn_x + r_x;
        mix[4] = (p_x <<< 1) + (yn_x <<< 1) + (r_x <<< 1);
        mix[5] = p_x - yn_x + r3;

        // maximum test wins when the limits cross
        for (int k = 0; k < 6; k++) begin
            if (mix[k] > dmax_x) begin
                n_d2[k] = r_duty_max;
            end else if (mix[k] <= dmin_x) begin
                n_d2[k] = r_duty_min;
            end else begin
                n_d2[k] = mix[k][DUTY_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d2 <= n_d2;
            r_f2 <= r_f1;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: duty sum plus rounding offset
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] n_sum;

    logic [DUTY_W-1:0]       r_d3 [6];
    logic [SUM_W-1:0]        r_sum3;
    logic signed [CMD_W-1:0] r_f3;

    always_comb begin
        n_sum = SUM_W'(3);
        for (int k = 0; k < 6; k++) begin
            n_sum = n_sum + SUM_W'(r_d2[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d3   <= r_d2;
            r_sum3 <= n_sum;
            r_f3   <= r_f2;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: divide by six through the reciprocal
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] prod;

    logic [DUTY_W-1:0]       r_d4 [6];
    logic [DUTY_W-1:0]       r_avg4;
    logic signed [CMD_W-1:0] r_f4;

    assign prod = PROD_W'(r_sum3) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d4   <= r_d3;
            r_avg4 <= prod[RSH+DUTY_W-1:RSH];
            r_f4   <= r_f3;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: weight-shift drive, result word register
    // ------------------------------------------------------------------
    logic signed [SW-1:0] w_x, wmin_x, wmax_x;
    logic [DUTY_W-1:0]    n_wd;
    t_mix_out             r_out;

    always_comb begin
        w_x    = SW'(r_f4) - signed'(SW'(r_avg4));
        wmin_x = signed'(SW'(r_weight_min));
        wmax_x = signed'(SW'(r_weight_max));
        if (w_x > wmax_x) begin
            n_wd = r_weight_max;
        end else if (w_x < wmin_x) begin
            n_wd = r_weight_min;
        end else begin
            n_wd = w_x[DUTY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.duty_one     <= r_d4[0];
            r_out.duty_two     <= r_d4[1];
            r_out.duty_three   <= r_d4[2];
            r_out.duty_four    <= r_d4[3];
            r_out.duty_five    <= r_d4[4];
            r_out.duty_six     <= r_d4[5];
            r_out.duty_average <= r_avg4;
            r_out.weight_drive <= n_wd;
        end
    end

    assign o_out_word = r_out;

endmodule
